// ----- design/sfbp_pkg.sv -----
package sfbp_pkg;

   // Largest data length a frame may announce
   localparam int MAX_DATA_LEN = 12;
   // Shortest data field that still carries index, pitch, roll and yaw
   localparam int MIN_PAYLOAD  = 7;
   // Width that holds a data length or a data byte count up to MAX_DATA_LEN
   localparam int LEN_W        = $clog2(MAX_DATA_LEN + 1);

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_ADDRESS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_FUNCTION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_COUNT      = 2'd2;

   // Configuration reset values
   localparam logic [7:0] RST_SENSOR_ADDRESS    = 8'd1;
   localparam logic [7:0] RST_FEEDBACK_FUNCTION = 8'd3;
   localparam logic [7:0] RST_SENSOR_COUNT      = 8'd4;

   // One decoded frame, handed from the parser to the output stage
   typedef struct packed {
      logic        valid;
      logic [7:0]  sensor_index;
      logic [15:0] pitch;
      logic [15:0] roll;
      logic [15:0] yaw;
   } sfbp_result_type;

endpackage

// ----- design/sfbp_parser.sv -----
module sfbp_parser
   import sfbp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   output sfbp_result_type      result
);

   typedef enum logic [2:0] {
      PH_ADDR,
      PH_FUNC,
      PH_LEN,
      PH_DATA,
      PH_CHECK
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] byte_count_ff, byte_count_in;
   logic [LEN_W-1:0] frame_length_ff, frame_length_in;
   logic [7:0]       running_sum_ff, running_sum_in;
   logic [7:0]       sensor_address_ff, feedback_function_ff, sensor_count_ff;
   logic [7:0]       index_ff;
   logic [7:0]       data_ff [1:6];
   logic [LEN_W-1:0] count_next;
   logic [7:0]       sum_next;
   logic             frame_ok;
   logic             result_valid;

   assign count_next = byte_count_ff + LEN_W'(1);
   assign sum_next   = running_sum_ff + rx_byte;

   // Checksum byte closes a good frame only with a full payload and a known sensor
   assign frame_ok = (running_sum_ff == rx_byte)
                  && (frame_length_ff >= LEN_W'(MIN_PAYLOAD))
                  && (index_ff != 8'd0)
                  && (index_ff <= sensor_count_ff);

   // Next parser state for the byte in this request
   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      frame_length_in = frame_length_ff;
      running_sum_in  = running_sum_ff;
      result_valid    = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_ADDR: begin
               if (rx_byte == sensor_address_ff) begin
                  running_sum_in = rx_byte;
                  phase_in       = PH_FUNC;
               end
            end
            PH_FUNC: begin
               if (rx_byte == feedback_function_ff) begin
                  running_sum_in = sum_next;
                  phase_in       = PH_LEN;
               end else begin
                  phase_in        = PH_ADDR;
                  byte_count_in   = '0;
                  frame_length_in = '0;
                  running_sum_in  = '0;
               end
            end
            PH_LEN: begin
               if (rx_byte == 8'd0 || rx_byte > 8'(MAX_DATA_LEN)) begin
                  phase_in        = PH_ADDR;
                  byte_count_in   = '0;
                  frame_length_in = '0;
                  running_sum_in  = '0;
               end else begin
                  frame_length_in = rx_byte[LEN_W-1:0];
                  byte_count_in   = '0;
                  running_sum_in  = sum_next;
                  phase_in        = PH_DATA;
               end
            end
            PH_DATA: begin
               running_sum_in = sum_next;
               byte_count_in  = count_next;
               if (count_next >= frame_length_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               result_valid    = frame_ok;
               phase_in        = PH_ADDR;
               byte_count_in   = '0;
               frame_length_in = '0;
               running_sum_in  = '0;
            end
            default: begin
               phase_in        = PH_ADDR;
               byte_count_in   = '0;
               frame_length_in = '0;
               running_sum_in  = '0;
            end
         endcase
      end
   end

   assign result = {result_valid, index_ff, data_ff[1], data_ff[2], data_ff[3], data_ff[4],
                    data_ff[5], data_ff[6]};

   // Hold parser state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff             <= PH_ADDR;
         byte_count_ff        <= '0;
         frame_length_ff      <= '0;
         running_sum_ff       <= '0;
         sensor_address_ff    <= RST_SENSOR_ADDRESS;
         feedback_function_ff <= RST_FEEDBACK_FUNCTION;
         sensor_count_ff      <= RST_SENSOR_COUNT;
      end else begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         frame_length_ff <= frame_length_in;
         running_sum_ff  <= running_sum_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SENSOR_ADDRESS:    sensor_address_ff    <= csr_wdata;
               CSR_FEEDBACK_FUNCTION: feedback_function_ff <= csr_wdata;
               CSR_SENSOR_COUNT:      sensor_count_ff      <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Capture the sensor index and the six word bytes as they arrive
   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_DATA) begin
         if (byte_count_ff == '0) begin
            index_ff <= rx_byte;
         end
         for (int i = 1; i <= 6; i++) begin
            if (byte_count_ff == LEN_W'(i)) begin
               data_ff[i] <= rx_byte;
            end
         end
      end
   end

   // A result comes only from a request, and only on the checksum byte
   a_result_on_request: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> accept && phase_ff == PH_CHECK)
      else $error("result without checksum request");

   // A frame that passed the length byte announces a legal length
   a_length_legal: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_CHECK) |->
         frame_length_ff != '0 && frame_length_ff <= LEN_W'(MAX_DATA_LEN))
      else $error("frame length out of range");

   // Data bytes never run past the announced length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> byte_count_ff < frame_length_ff)
      else $error("data byte count past frame length");

endmodule

// ----- design/sensor_frame_byte_parser_unit.sv -----
// A result appears on rsp_valid in the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle while req_ready is high; parser state and running checksum update on each byte taken.
// req_ready drops only while a finished result waits in the output register and rsp_ready
// is low.
// Reset (synchronous, active high): parser returns to address hunting, configuration takes
// its defaults, output register empties.
module sensor_frame_byte_parser_unit
   import sfbp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_sensor_index,
   output logic [15:0]          rsp_pitch,
   output logic [15:0]          rsp_roll,
   output logic [15:0]          rsp_yaw,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   sfbp_result_type par_result;
   logic            accept;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_index_ff;
   logic [15:0]     rsp_pitch_ff, rsp_roll_ff, rsp_yaw_ff;

   // Take a request whenever the output register is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   sfbp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .result    (par_result)
   );

   // Output register: load a new result, else drop the taken one
   always_comb begin
      if (par_result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (par_result.valid) begin
         rsp_index_ff <= par_result.sensor_index;
         rsp_pitch_ff <= par_result.pitch;
         rsp_roll_ff  <= par_result.roll;
         rsp_yaw_ff   <= par_result.yaw;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sensor_index = rsp_index_ff;
   assign rsp_pitch        = rsp_pitch_ff;
   assign rsp_roll         = rsp_roll_ff;
   assign rsp_yaw          = rsp_yaw_ff;

   // A stall on the input comes only from a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a waiting result");

   // A new result never lands on one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      par_result.valid |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten before it was taken");

   // Every shown result was loaded by the parser in the cycle before, or was waiting
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(par_result.valid))
      else $error("result shown without a parsed frame");

endmodule
